// File: sv/ppws_pkg.sv
// shared widths, codes and types of the packed pixel window store
package ppws_pkg;

    localparam int COORD_W     = 16;
    localparam int BPP_W       = 6;
    localparam int STORE_BYTES = 16384;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    // byte position floor(p*bpp/8)
    localparam int BPOS_W      = COORD_W + BPP_W - 3;
    localparam int MUL_A_W     = BPOS_W + 1;
    localparam int MUL_B_W     = COORD_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int BASE_W      = PROD_W + 1;
    localparam int PIX_W       = 32;
    localparam int STAT_W      = 2;
    localparam int OUT_CNT_W   = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(8);

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_APPEND = 3'd2,
        OP_FILL   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_BEYOND  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BPP    = 3'd0,
        REG_LEFT   = 3'd1,
        REG_TOP    = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_BOTTOM = 3'd4
    } t_cfg_reg;

endpackage

// File: sv/ppws_mul.sv
// shared registered multiplier used for byte positions and row offsets
module ppws_mul (
    input  logic                              i_clk,
    input  logic [ppws_pkg::MUL_A_W-1:0]      i_a,
    input  logic [ppws_pkg::MUL_B_W-1:0]      i_b,
    output logic [ppws_pkg::PROD_W-1:0]       o_prod
);

    logic [ppws_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ppws_pkg::PROD_W'(i_a) * ppws_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: sv/packed_pixel_window_store.sv
// top level of the packed pixel window store
//
// byte store for one rectangular window of a packed bitmap (1, 2, 4, 8, 16, 24
// or 32 bits per pixel). an item is taken when i_start is high and o_busy is
// low; its single result shows for exactly one cycle with o_done high and
// cannot be held off, so the receiver must take it then. append, clear and
// unused opcodes finish without leaving idle and a new item may follow at once.
// read and write run a small sequencer around one shared registered
// multiplier (x*bpp, left*bpp, right*bpp, row bytes times row offset) and
// then touch the byte memory (one write port, one registered read port). a
// fill first sizes the window with the multiplier and then writes one byte
// per cycle over the filled length, at most 16384 bytes. checks that fail
// early (outside window, bad depth, empty window) finish without leaving
// idle. configuration must be written only while the block is idle; the
// block itself does not enforce it.
module packed_pixel_window_store (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [2:0]                            i_opcode,
    input  logic [ppws_pkg::COORD_W-1:0]          i_pixel_x,
    input  logic [ppws_pkg::COORD_W-1:0]          i_pixel_y,
    input  logic [ppws_pkg::PIX_W-1:0]            i_pixel_in,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_cfg_we,
    input  logic [ppws_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ppws_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_done,
    output logic [ppws_pkg::PIX_W-1:0]            o_pixel_out,
    output logic [ppws_pkg::STAT_W-1:0]           o_status,
    output logic [ppws_pkg::OUT_CNT_W-1:0]        o_stored_bytes
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_BX   = 12'b000000000010,
        S_BL   = 12'b000000000100,
        S_BR   = 12'b000000001000,
        S_ROW  = 12'b000000010000,
        S_MR   = 12'b000000100000,
        S_BASE = 12'b000001000000,
        S_CHK  = 12'b000010000000,
        S_RD   = 12'b000100000000,
        S_RX   = 12'b001000000000,
        S_WR   = 12'b010000000000,
        S_FILL = 12'b100000000000
    } t_state;

    // config
    logic [ppws_pkg::BPP_W-1:0]   r_bpp;
    logic [ppws_pkg::COORD_W-1:0] r_left, r_top, r_right, r_bottom;

    // sequencer and item registers
    t_state                          r_state, n_state;
    ppws_pkg::t_opcode               r_op, n_op;
    logic [ppws_pkg::COORD_W-1:0]    r_x, n_x;
    logic [ppws_pkg::PIX_W-1:0]      r_val, n_val;
    logic [7:0]                      r_db, n_db;
    logic [ppws_pkg::MUL_B_W-1:0]    r_dy, n_dy;
    logic [ppws_pkg::BPOS_W-1:0]     r_bx, n_bx, r_bl, n_bl;
    logic [2:0]                      r_boff, n_boff;
    logic [ppws_pkg::MUL_A_W-1:0]    r_row, n_row;
    logic [ppws_pkg::BASE_W-1:0]     r_base, n_base;
    logic [ppws_pkg::CNT_W-1:0]      r_ptr, n_ptr;
    logic [ppws_pkg::CNT_W-1:0]      r_fill_n, n_fill_n;
    logic [1:0]                      r_k, n_k;
    logic [ppws_pkg::PIX_W-1:0]      r_pix, n_pix;
    logic [ppws_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_done, n_done;
    ppws_pkg::t_status               r_status, n_status;
    logic [ppws_pkg::PIX_W-1:0]      r_pix_out, n_pix_out;

    // byte memory
    logic [7:0]                      mem [ppws_pkg::STORE_BYTES];
    logic [7:0]                      r_rdata;
    logic                            mem_we;
    logic [ppws_pkg::ADDR_W-1:0]     mem_wa;
    logic [7:0]                      mem_wd;

    // shared multiplier
    logic [ppws_pkg::MUL_A_W-1:0]    mul_a;
    logic [ppws_pkg::MUL_B_W-1:0]    mul_b;
    logic [ppws_pkg::PROD_W-1:0]     prod;

    // decoded depth
    logic                            depth_ok;
    logic                            sub_byte;
    logic [2:0]                      pbytes;
    logic [2:0]                      sh;
    logic [7:0]                      m8;
    logic                            last_byte;

    ppws_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign depth_ok  = (r_bpp == 6'd1) || (r_bpp == 6'd2) || (r_bpp == 6'd4) ||
                       (r_bpp == 6'd8) || (r_bpp == 6'd16) || (r_bpp == 6'd24) ||
                       (r_bpp == 6'd32);
    assign sub_byte  = (r_bpp < 6'd8);
    assign pbytes    = sub_byte ? 3'd1 : 3'(r_bpp >> 3);
    // msb-first position of the pixel inside its byte
    assign sh        = 3'(4'd8 - r_bpp[3:0] - {1'b0, r_boff});
    assign m8        = 8'((9'd1 << r_bpp[2:0]) - 9'd1);
    assign last_byte = ({1'b0, r_k} == (pbytes - 3'd1));

    // operand select for the shared multiplier
    always_comb begin
        mul_a = ppws_pkg::MUL_A_W'(r_x);
        mul_b = ppws_pkg::MUL_B_W'(r_bpp);
        unique case (r_state)
            S_BL: mul_a = ppws_pkg::MUL_A_W'(r_left);
            S_BR: mul_a = ppws_pkg::MUL_A_W'(r_right);
            S_MR: begin
                mul_a = r_row;
                mul_b = r_dy;
            end
            default: mul_a = ppws_pkg::MUL_A_W'(r_x);
        endcase
    end

    always_comb begin
        logic [ppws_pkg::COORD_W-1:0] dy;
        logic                         in_win;
        logic                         big;
        logic [ppws_pkg::PIX_W-1:0]   acc;

        n_state   = r_state;
        n_op      = r_op;
        n_x       = r_x;
        n_val     = r_val;
        n_db      = r_db;
        n_dy      = r_dy;
        n_bx      = r_bx;
        n_bl      = r_bl;
        n_boff    = r_boff;
        n_row     = r_row;
        n_base    = r_base;
        n_ptr     = r_ptr;
        n_fill_n  = r_fill_n;
        n_k       = r_k;
        n_pix     = r_pix;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_pix_out = r_pix_out;
        mem_we    = 1'b0;
        mem_wa    = r_ptr[ppws_pkg::ADDR_W-1:0];
        mem_wd    = r_db;

        dy     = i_pixel_y - r_top;
        in_win = (i_pixel_x >= r_left) && (i_pixel_x <= r_right) &&
                 (i_pixel_y >= r_top) && (i_pixel_y <= r_bottom);
        big    = (prod > ppws_pkg::PROD_W'(ppws_pkg::STORE_BYTES));
        acc    = r_pix | (ppws_pkg::PIX_W'(r_rdata) << {r_k, 3'b000});

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op      = ppws_pkg::t_opcode'(i_opcode);
                    n_x       = i_pixel_x;
                    n_val     = i_pixel_in;
                    n_db      = i_data_byte;
                    n_pix_out = '0;
                    n_status  = ppws_pkg::ST_OK;
                    n_done    = 1'b1;
                    unique case (ppws_pkg::t_opcode'(i_opcode))
                        ppws_pkg::OP_READ, ppws_pkg::OP_WRITE: begin
                            if (!in_win) begin
                                n_status = ppws_pkg::ST_OUTSIDE;
                            end else if (!depth_ok ||
                                         ({1'b0, dy} > (ppws_pkg::COORD_W + 1)'(
                                             ppws_pkg::STORE_BYTES))) begin
                                n_status = ppws_pkg::ST_BEYOND;
                            end else begin
                                n_dy    = ppws_pkg::MUL_B_W'(dy);
                                n_done  = 1'b0;
                                n_state = S_BX;
                            end
                        end
                        ppws_pkg::OP_APPEND: begin
                            if (r_count < ppws_pkg::CNT_W'(ppws_pkg::STORE_BYTES)) begin
                                mem_we  = 1'b1;
                                mem_wa  = r_count[ppws_pkg::ADDR_W-1:0];
                                mem_wd  = i_data_byte;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = ppws_pkg::ST_FULL;
                            end
                        end
                        ppws_pkg::OP_FILL: begin
                            n_count = '0;
                            if (!depth_ok) begin
                                n_status = ppws_pkg::ST_BEYOND;
                            end else if ((r_right >= r_left) && (r_bottom >= r_top)) begin
                                // row count feeds the multiplier in place of the row offset
                                n_dy    = ppws_pkg::MUL_B_W'(r_bottom - r_top) + 1'b1;
                                n_done  = 1'b0;
                                n_state = S_BL;
                            end
                        end
                        ppws_pkg::OP_CLEAR: n_count = '0;
                        default: n_status = ppws_pkg::ST_OK;
                    endcase
                end
            end
            S_BX: n_state = S_BL;
            S_BL: begin
                // product of x*bpp is ready
                n_bx    = prod[ppws_pkg::BPOS_W+2:3];
                n_boff  = prod[2:0];
                n_state = S_BR;
            end
            S_BR: begin
                n_bl    = prod[ppws_pkg::BPOS_W+2:3];
                n_state = S_ROW;
            end
            S_ROW: begin
                n_row = ppws_pkg::MUL_A_W'(prod[ppws_pkg::BPOS_W+2:3]) -
                        ppws_pkg::MUL_A_W'(r_bl) + ppws_pkg::MUL_A_W'(pbytes);
                n_state = S_MR;
            end
            S_MR: n_state = S_BASE;
            S_BASE: begin
                if (r_op == ppws_pkg::OP_FILL) begin
                    n_ptr = '0;
                    if (big) begin
                        n_fill_n = ppws_pkg::CNT_W'(ppws_pkg::STORE_BYTES);
                        n_status = ppws_pkg::ST_FULL;
                    end else begin
                        n_fill_n = ppws_pkg::CNT_W'(prod);
                    end
                    n_state = S_FILL;
                end else begin
                    n_base = ppws_pkg::BASE_W'(r_bx) - ppws_pkg::BASE_W'(r_bl) +
                             ppws_pkg::BASE_W'(prod);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if ((r_base + ppws_pkg::BASE_W'(pbytes)) > ppws_pkg::BASE_W'(r_count)) begin
                    n_status = ppws_pkg::ST_BEYOND;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = ppws_pkg::CNT_W'(r_base);
                    n_k     = '0;
                    n_pix   = '0;
                    n_state = (r_op == ppws_pkg::OP_WRITE && !sub_byte) ? S_WR : S_RD;
                end
            end
            S_RD: n_state = S_RX;
            S_RX: begin
                if (sub_byte) begin
                    if (r_op == ppws_pkg::OP_READ) begin
                        n_pix_out = ppws_pkg::PIX_W'((r_rdata >> sh) & m8);
                    end else begin
                        // read-modify-write of the shared byte
                        mem_we = 1'b1;
                        mem_wd = (r_rdata & ~(m8 << sh)) | ((r_val[7:0] & m8) << sh);
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_pix = acc;
                    if (last_byte) begin
                        n_pix_out = acc;
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_ptr   = r_ptr + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_WR: begin
                // little-endian byte order
                mem_we = 1'b1;
                mem_wd = 8'(r_val >> {r_k, 3'b000});
                if (last_byte) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k   = r_k + 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wd = r_db;
                if ((r_ptr + 1'b1) == r_fill_n) begin
                    n_count = r_fill_n;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // byte memory with one write port and one read port, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[r_ptr[ppws_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_count  <= '0;
            r_bpp    <= ppws_pkg::BPP_RESET;
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
            if (i_cfg_we) begin
                unique case (ppws_pkg::t_cfg_reg'(i_cfg_index))
                    ppws_pkg::REG_BPP:    r_bpp    <= i_cfg_data[ppws_pkg::BPP_W-1:0];
                    ppws_pkg::REG_LEFT:   r_left   <= i_cfg_data[ppws_pkg::COORD_W-1:0];
                    ppws_pkg::REG_TOP:    r_top    <= i_cfg_data[ppws_pkg::COORD_W-1:0];
                    ppws_pkg::REG_RIGHT:  r_right  <= i_cfg_data[ppws_pkg::COORD_W-1:0];
                    ppws_pkg::REG_BOTTOM: r_bottom <= i_cfg_data[ppws_pkg::COORD_W-1:0];
                    default:              r_bpp    <= r_bpp;
                endcase
            end
        end
    end

    // item payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_x       <= n_x;
        r_val     <= n_val;
        r_db      <= n_db;
        r_dy      <= n_dy;
        r_bx      <= n_bx;
        r_bl      <= n_bl;
        r_boff    <= n_boff;
        r_row     <= n_row;
        r_base    <= n_base;
        r_ptr     <= n_ptr;
        r_fill_n  <= n_fill_n;
        r_k       <= n_k;
        r_pix     <= n_pix;
        r_status  <= n_status;
        r_pix_out <= n_pix_out;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_pixel_out    = r_pix_out;
    assign o_status       = r_status;
    assign o_stored_bytes = ppws_pkg::OUT_CNT_W'(r_count);

endmodule
